@@ src/prqs_pkg.sv @@
// Package for the priority ready-queue scheduler: widths, codes and request types.
// Depends on nothing; used by the interfaces and every module.
package prqs_pkg;

  localparam int unsigned PrioLevels = 32;
  localparam int unsigned MaxTasks   = 64;
  localparam int unsigned PrioW      = $clog2(PrioLevels);
  localparam int unsigned TaskW      = $clog2(MaxTasks);
  localparam int unsigned DepthW     = 15;
  localparam logic [DepthW-1:0] NestMax = '1;

  typedef enum logic [2:0] {
    FuncInsert   = 3'd0,
    FuncRemove   = 3'd1,
    FuncSchedule = 3'd2,
    FuncLock     = 3'd3,
    FuncUnlock   = 3'd4,
    FuncStart    = 3'd5
  } func_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] priority_req;
    logic             in_interrupt;
  } req_t;

  typedef struct packed {
    logic              switch_now;
    logic [TaskW-1:0]  to_task;
    logic [TaskW-1:0]  prior_task;
    logic              from_valid;
    logic              switch_kind;
    logic [PrioW-1:0]  to_priority;
    logic              none_ready;
    logic [DepthW-1:0] lock_depth;
  } rsp_t;

  // Lowest set bit of the ready bitmap.
  function automatic logic [PrioW-1:0] first_set(input logic [PrioLevels-1:0] bits);
    logic [PrioW-1:0] idx;
    idx = '0;
    for (int i = PrioLevels - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = PrioW'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ src/prqs_req_if.sv @@
// Request channel interface for the scheduler.
// Depends on prqs_pkg.
interface prqs_req_if;
  logic           valid;
  logic           ready;
  prqs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/prqs_rsp_if.sv @@
// Result channel interface for the scheduler.
// Depends on prqs_pkg.
interface prqs_rsp_if;
  logic           valid;
  logic           ready;
  prqs_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/prqs_link_mem.sv @@
// Link tables: next and prev pointers for each task, synchronous read.
// Depends on prqs_pkg.
module prqs_link_mem (
  input  logic                         clk_i,
  input  logic [prqs_pkg::TaskW-1:0]   raddr_i,
  output logic [prqs_pkg::TaskW-1:0]   next_o,
  output logic [prqs_pkg::TaskW-1:0]   prev_o,
  input  logic                         nwe_i,
  input  logic [prqs_pkg::TaskW-1:0]   naddr_i,
  input  logic [prqs_pkg::TaskW-1:0]   ndata_i,
  input  logic                         pwe_i,
  input  logic [prqs_pkg::TaskW-1:0]   paddr_i,
  input  logic [prqs_pkg::TaskW-1:0]   pdata_i
);
  logic [prqs_pkg::TaskW-1:0] next_mem [prqs_pkg::MaxTasks];
  logic [prqs_pkg::TaskW-1:0] prev_mem [prqs_pkg::MaxTasks];

  always_ff @(posedge clk_i) begin
    if (nwe_i) begin
      next_mem[naddr_i] <= ndata_i;
    end
    if (pwe_i) begin
      prev_mem[paddr_i] <= pdata_i;
    end
    next_o <= next_mem[raddr_i];
    prev_o <= prev_mem[raddr_i];
  end
endmodule

@@ src/prqs_queue_mem.sv @@
// Head and tail table for each priority level, synchronous read.
// Depends on prqs_pkg.
module prqs_queue_mem (
  input  logic                       clk_i,
  input  logic [prqs_pkg::PrioW-1:0] raddr_i,
  output logic [prqs_pkg::TaskW-1:0] head_o,
  output logic [prqs_pkg::TaskW-1:0] tail_o,
  input  logic [prqs_pkg::PrioW-1:0] waddr_i,
  input  logic                       hwe_i,
  input  logic [prqs_pkg::TaskW-1:0] hdata_i,
  input  logic                       twe_i,
  input  logic [prqs_pkg::TaskW-1:0] tdata_i
);
  logic [prqs_pkg::TaskW-1:0] head_mem [prqs_pkg::PrioLevels];
  logic [prqs_pkg::TaskW-1:0] tail_mem [prqs_pkg::PrioLevels];

  always_ff @(posedge clk_i) begin
    if (hwe_i) begin
      head_mem[waddr_i] <= hdata_i;
    end
    if (twe_i) begin
      tail_mem[waddr_i] <= tdata_i;
    end
    head_o <= head_mem[raddr_i];
    tail_o <= tail_mem[raddr_i];
  end
endmodule

@@ src/priority_ready_queue_scheduler_top.sv @@
// Top level of the priority ready-queue scheduler: control sequencer, bitmap,
// running task and lock depth. Depends on prqs_pkg, both interfaces and both memories.
//
//  channel | dir | payload                        | handshake
//  req     | in  | func, task_id, priority_req, ..| valid/ready
//  rsp     | out | switch_now ... lock_depth      | valid/ready
//
// Every request passes through three states: accept in idle, a read state for the synchronous
// reads of the head/tail and link memories, then the write-back and result in the exec state.
// The result sits in an output register; the next request is accepted when
// that register is free or being taken. Reset clears the bitmap, running
// task and lock depth; the memories are not cleared.
module priority_ready_queue_scheduler_top (
  input logic     clk_i,
  input logic     rst_ni,
  prqs_req_if.sink   req,
  prqs_rsp_if.source rsp
);
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRead = 3'b010,
    StExec = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  prqs_pkg::req_t                req_q;
  logic [prqs_pkg::PrioLevels-1:0] ready_q, ready_d;
  logic [prqs_pkg::TaskW-1:0]    run_q, run_d;
  logic                          run_vld_q, run_vld_d;
  logic [prqs_pkg::DepthW-1:0]   nest_q, nest_d;
  prqs_pkg::rsp_t                out_q, out_d;
  logic                          out_vld_q, out_vld_d;

  logic [prqs_pkg::PrioW-1:0] q_raddr, q_waddr, best;
  logic [prqs_pkg::TaskW-1:0] head_rd, tail_rd, hdata, tdata;
  logic                       hwe, twe;
  logic [prqs_pkg::TaskW-1:0] nxt_rd, prv_rd, naddr, ndata, paddr, pdata;
  logic                       nwe, pwe;

  logic accept, out_free, lvl_rdy, do_sched;

  assign out_free  = !out_vld_q || rsp.ready;
  assign req.ready = (state_q == StIdle) && out_free;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_vld_q;
  assign rsp.data  = out_q;

  assign best    = prqs_pkg::first_set(ready_q);
  assign lvl_rdy = ready_q[req_q.priority_req];
  // Schedule-type requests read the best level; list edits read their own level.
  assign q_raddr = (req_q.func == prqs_pkg::FuncInsert ||
                    req_q.func == prqs_pkg::FuncRemove) ?
                   req_q.priority_req : best;
  assign q_waddr = req_q.priority_req;

  prqs_queue_mem u_queue (
    .clk_i, .raddr_i(q_raddr), .head_o(head_rd), .tail_o(tail_rd),
    .waddr_i(q_waddr), .hwe_i(hwe), .hdata_i(hdata), .twe_i(twe), .tdata_i(tdata)
  );

  always_comb begin
    state_d   = state_q;
    ready_d   = ready_q;
    run_d     = run_q;
    run_vld_d = run_vld_q;
    nest_d    = nest_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp.ready;
    hwe = 1'b0; twe = 1'b0; hdata = req_q.task_id; tdata = req_q.task_id;
    nwe = 1'b0; pwe = 1'b0;
    naddr = req_q.task_id; ndata = req_q.task_id;
    paddr = req_q.task_id; pdata = req_q.task_id;
    do_sched = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StRead;
      end
      StRead: begin
        state_d = StExec;
      end
      StExec: begin
        state_d = StIdle;
        out_d = '0;
        case (req_q.func)
          prqs_pkg::FuncInsert: begin
            if (lvl_rdy) begin
              nwe = 1'b1; naddr = tail_rd;
              pwe = 1'b1; pdata = tail_rd;
              twe = 1'b1;
            end else begin
              // New list: self links are written below through the second port.
              pwe = 1'b1;
              hwe = 1'b1; twe = 1'b1;
              ready_d[req_q.priority_req] = 1'b1;
            end
          end
          prqs_pkg::FuncRemove: begin
            if (lvl_rdy) begin
              if (head_rd == req_q.task_id && tail_rd == req_q.task_id) begin
                ready_d[req_q.priority_req] = 1'b0;
              end else if (head_rd == req_q.task_id) begin
                hwe = 1'b1; hdata = nxt_rd;
              end else if (tail_rd == req_q.task_id) begin
                twe = 1'b1; tdata = prv_rd;
              end else begin
                nwe = 1'b1; naddr = prv_rd; ndata = nxt_rd;
                pwe = 1'b1; paddr = nxt_rd; pdata = prv_rd;
              end
            end
          end
          prqs_pkg::FuncSchedule: do_sched = (nest_q == '0);
          prqs_pkg::FuncLock: begin
            if (nest_q != prqs_pkg::NestMax) nest_d = nest_q + 1'b1;
          end
          prqs_pkg::FuncUnlock: begin
            if (nest_q > prqs_pkg::DepthW'(1)) begin
              nest_d = nest_q - 1'b1;
            end else begin
              nest_d   = '0;
              do_sched = 1'b1;
            end
          end
          prqs_pkg::FuncStart: do_sched = 1'b1;
          default: ;
        endcase
        if (do_sched) begin
          if (ready_q == '0) begin
            out_d.none_ready = 1'b1;
          end else begin
            out_d.to_task     = head_rd;
            out_d.to_priority = best;
            if (req_q.func == prqs_pkg::FuncStart) begin
              out_d.switch_now = 1'b1;
              run_d = head_rd; run_vld_d = 1'b1;
            end else if (!run_vld_q || run_q != head_rd) begin
              out_d.switch_now  = 1'b1;
              out_d.prior_task  = run_vld_q ? run_q : '0;
              out_d.from_valid  = run_vld_q;
              out_d.switch_kind = req_q.in_interrupt;
              run_d = head_rd; run_vld_d = 1'b1;
            end
          end
        end
        out_d.lock_depth = nest_d;
        out_vld_d = 1'b1;
      end
      default: state_d = StIdle;
    endcase
  end

  // Insert into an empty list needs next[t] = t as well; both link ports
  // target t then, so the next port carries it when not used for the tail.
  logic                       nwe_x;
  logic [prqs_pkg::TaskW-1:0] naddr_x;
  logic                       self_nxt;
  assign self_nxt = (state_q == StExec) && (req_q.func == prqs_pkg::FuncInsert);
  assign nwe_x    = nwe || self_nxt;
  assign naddr_x  = naddr;

  // Third link write (next[t] = t when appending) is done from the registered fix_q flag.
  logic fix_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StExec) req_q <= req_q;
    else if (accept) req_q <= req.data;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ready_q   <= '0;
      run_q     <= '0;
      run_vld_q <= 1'b0;
      nest_q    <= '0;
      out_vld_q <= 1'b0;
      fix_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      ready_q   <= ready_d;
      run_q     <= run_d;
      run_vld_q <= run_vld_d;
      nest_q    <= nest_d;
      out_vld_q <= out_vld_d;
      fix_q     <= self_nxt && lvl_rdy;
    end
  end

  // The appended task's own next link is written in the idle cycle that follows.
  logic [prqs_pkg::TaskW-1:0] lnk_naddr, lnk_ndata;
  logic                       lnk_nwe;
  always_comb begin
    lnk_nwe   = nwe_x || fix_q;
    lnk_naddr = fix_q ? req_q.task_id : naddr_x;
    lnk_ndata = fix_q ? req_q.task_id : ndata;
  end

  prqs_link_mem u_link (
    .clk_i, .raddr_i(req_q.task_id), .next_o(nxt_rd), .prev_o(prv_rd),
    .nwe_i(lnk_nwe), .naddr_i(lnk_naddr), .ndata_i(lnk_ndata),
    .pwe_i(pwe), .paddr_i(paddr), .pdata_i(pdata)
  );
endmodule

@@ bench/prqs_scoreboard.sv @@
// Checker for the ready-queue scheduler: watches both channels, predicts each result.
// Depends on prqs_pkg and the request and result channel interfaces.
module prqs_scoreboard (
  input  logic   clk_i,
  input  logic   rst_ni,
  prqs_req_if    req,
  prqs_rsp_if    rsp,
  output int     errors_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [prqs_pkg::PrioLevels-1:0] ready_bits;
  logic [prqs_pkg::TaskW-1:0]      q_head [prqs_pkg::PrioLevels];
  logic [prqs_pkg::TaskW-1:0]      q_tail [prqs_pkg::PrioLevels];
  logic [prqs_pkg::TaskW-1:0]      next_of [prqs_pkg::MaxTasks];
  logic [prqs_pkg::TaskW-1:0]      prev_of [prqs_pkg::MaxTasks];
  logic [prqs_pkg::TaskW-1:0]      running;
  logic                            running_vld;
  logic [prqs_pkg::DepthW-1:0]     depth;
  prqs_pkg::rsp_t                  expected_q [$];

  // Picks the head of the lowest-numbered ready level and updates the running task.
  task automatic pick_next(input bit is_start, input logic irq, inout prqs_pkg::rsp_t o);
    int lvl;
    logic [prqs_pkg::TaskW-1:0] to;
    lvl = -1;
    for (int i = prqs_pkg::PrioLevels - 1; i >= 0; i--) begin
      if (ready_bits[i]) lvl = i;
    end
    if (lvl < 0) begin
      o.none_ready = 1'b1;
      return;
    end
    to = q_head[lvl];
    o.to_task = to;
    o.to_priority = lvl[prqs_pkg::PrioW-1:0];
    if (is_start) begin
      o.switch_now = 1'b1;
      running = to;
      running_vld = 1'b1;
    end else if (!running_vld || running != to) begin
      o.switch_now = 1'b1;
      o.prior_task = running_vld ? running : '0;
      o.from_valid = running_vld;
      o.switch_kind = irq;
      running = to;
      running_vld = 1'b1;
    end
  endtask

  task automatic predict_request(input prqs_pkg::req_t r, output prqs_pkg::rsp_t o);
    logic [prqs_pkg::TaskW-1:0] t, nx, pv;
    logic [prqs_pkg::PrioW-1:0] p;
    t = r.task_id;
    p = r.priority_req;
    o = '0;
    case (r.func)
      prqs_pkg::FuncInsert: begin
        if (ready_bits[p]) begin
          next_of[q_tail[p]] = t;
          prev_of[t] = q_tail[p];
          next_of[t] = t;
          q_tail[p] = t;
        end else begin
          q_head[p] = t;
          q_tail[p] = t;
          next_of[t] = t;
          prev_of[t] = t;
          ready_bits[p] = 1'b1;
        end
      end
      prqs_pkg::FuncRemove: begin
        if (ready_bits[p]) begin
          nx = next_of[t];
          pv = prev_of[t];
          if (q_head[p] == t && q_tail[p] == t) ready_bits[p] = 1'b0;
          else if (q_head[p] == t) q_head[p] = nx;
          else if (q_tail[p] == t) q_tail[p] = pv;
          else begin
            next_of[pv] = nx;
            prev_of[nx] = pv;
          end
        end
      end
      prqs_pkg::FuncSchedule: if (depth == '0) pick_next(1'b0, r.in_interrupt, o);
      prqs_pkg::FuncLock: if (depth != prqs_pkg::NestMax) depth = depth + 1'b1;
      prqs_pkg::FuncUnlock: begin
        if (depth > 1) depth = depth - 1'b1;
        else begin
          depth = '0;
          pick_next(1'b0, r.in_interrupt, o);
        end
      end
      prqs_pkg::FuncStart: pick_next(1'b1, r.in_interrupt, o);
      default: ;
    endcase
    o.lock_depth = depth;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    prqs_pkg::rsp_t e, a;
    if (!rst_ni) begin
      ready_bits = '0;
      running = '0;
      running_vld = 1'b0;
      depth = '0;
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (req.valid && req.ready) begin
        predict_request(req.data, e);
        expected_q.push_back(e);
      end
      if (rsp.valid && rsp.ready) begin
        a = rsp.data;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("switch_now", 32'(e.switch_now), 32'(a.switch_now));
          check_field("to_task", 32'(e.to_task), 32'(a.to_task));
          check_field("prior_task", 32'(e.prior_task), 32'(a.prior_task));
          check_field("from_valid", 32'(e.from_valid), 32'(a.from_valid));
          check_field("switch_kind", 32'(e.switch_kind), 32'(a.switch_kind));
          check_field("to_priority", 32'(e.to_priority), 32'(a.to_priority));
          check_field("none_ready", 32'(e.none_ready), 32'(a.none_ready));
          check_field("lock_depth", 32'(e.lock_depth), 32'(a.lock_depth));
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ bench/priority_ready_queue_scheduler_top_tb.sv @@
// Testbench top for the ready-queue scheduler: clock, reset, requests and verdict.
// Depends on prqs_pkg, both channel interfaces, the block and prqs_scoreboard.
module priority_ready_queue_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   idle_cycles;
  int   hold_cycles;
  bit   no_gaps;
  bit   member [prqs_pkg::MaxTasks];
  bit   written [prqs_pkg::MaxTasks];
  logic [prqs_pkg::PrioW-1:0] member_prio [prqs_pkg::MaxTasks];

  prqs_req_if req ();
  prqs_rsp_if rsp ();

  priority_ready_queue_scheduler_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .rsp   (rsp)
  );

  prqs_scoreboard u_scoreboard (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .rsp      (rsp),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Nothing accepted on either channel for too long means the block hung.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls per result, plus one long hold-off on request.
  initial begin
    int w;
    bit held;
    held = 1'b0;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0 && !held) begin
        rsp.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        held = 1'b1;
      end
      w = no_gaps ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        rsp.ready = 1'b0;
        repeat (w) @(negedge clk_i);
      end
      rsp.ready = 1'b1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
    end
  end

  task automatic send(input logic [2:0] f, input int t, input int p, input bit irq);
    prqs_pkg::req_t r;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    r.func = f;
    r.task_id = t[prqs_pkg::TaskW-1:0];
    r.priority_req = p[prqs_pkg::PrioW-1:0];
    r.in_interrupt = irq;
    req.data = r;
    req.valid = 1'b1;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (f == prqs_pkg::FuncInsert) begin
      written[t] = 1'b1;
      member[t] = 1'b1;
      member_prio[t] = p[prqs_pkg::PrioW-1:0];
    end else if (f == prqs_pkg::FuncRemove && member[t] &&
                 member_prio[t] == p[prqs_pkg::PrioW-1:0]) begin
      member[t] = 1'b0;
    end
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin
    int sel, t, n;
    req.valid = 1'b0;
    req.data = '0;
    hold_cycles = 0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty cases, head, tail and middle removal, locking.
    send(prqs_pkg::FuncStart, 0, 0, 1);
    send(prqs_pkg::FuncSchedule, 0, 0, 1);
    send(prqs_pkg::FuncInsert, 0, 31, 0);
    send(prqs_pkg::FuncInsert, 63, 0, 0);
    send(prqs_pkg::FuncInsert, 5, 0, 1);
    send(prqs_pkg::FuncSchedule, 0, 0, 1);
    send(prqs_pkg::FuncSchedule, 0, 0, 0);
    send(prqs_pkg::FuncLock, 0, 0, 0);
    send(prqs_pkg::FuncRemove, 63, 0, 0);
    send(prqs_pkg::FuncSchedule, 0, 0, 1);
    send(prqs_pkg::FuncUnlock, 0, 0, 1);
    send(prqs_pkg::FuncUnlock, 0, 0, 0);
    send(prqs_pkg::FuncRemove, 5, 0, 0);
    send(prqs_pkg::FuncInsert, 10, 31, 0);
    send(prqs_pkg::FuncInsert, 20, 31, 0);
    send(prqs_pkg::FuncInsert, 42, 31, 0);
    send(prqs_pkg::FuncRemove, 20, 31, 0);
    send(prqs_pkg::FuncRemove, 42, 31, 1);
    send(prqs_pkg::FuncRemove, 10, 7, 0);
    send(prqs_pkg::FuncInsert, 0, 31, 0);
    send(prqs_pkg::FuncRemove, 63, 31, 0);
    send(prqs_pkg::FuncStart, 0, 0, 0);
    send(3'd6, 21, 21, 1);
    send(3'd7, 42, 10, 0);
    drain();

    // Random part: mostly well-formed inserts and removes, some noise.
    for (int i = 0; i < 800; i++) begin
      no_gaps = (i >= 100 && i < 200);
      if (i == 300) hold_cycles = 300;
      if (i == 500) drain();
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        t = $urandom_range(0, prqs_pkg::MaxTasks - 1);
        n = 0;
        while (member[t] && n < 8 && sel > 2) begin
          t = $urandom_range(0, prqs_pkg::MaxTasks - 1);
          n++;
        end
        send(prqs_pkg::FuncInsert, t,
             (sel < 25) ? $urandom_range(0, 7) : $urandom_range(0, 31),
             1'($urandom_range(0, 1)));
      end else if (sel < 60) begin
        t = $urandom_range(0, prqs_pkg::MaxTasks - 1);
        n = 0;
        while (!(sel < 55 ? member[t] : written[t]) && n < 64) begin
          t = (t + 1) % prqs_pkg::MaxTasks;
          n++;
        end
        if (!written[t]) begin
          send(prqs_pkg::FuncSchedule, 0, 0, 1'($urandom_range(0, 1)));
        end else if (sel < 55) begin
          send(prqs_pkg::FuncRemove, t, member_prio[t], 1'($urandom_range(0, 1)));
        end else begin
          send(prqs_pkg::FuncRemove, t, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
        end
      end else if (sel < 80) begin
        send(prqs_pkg::FuncSchedule, $urandom_range(0, 63), $urandom_range(0, 31),
             1'($urandom_range(0, 1)));
      end else if (sel < 87) begin
        send(prqs_pkg::FuncLock, 0, 0, 1'($urandom_range(0, 1)));
      end else if (sel < 95) begin
        send(prqs_pkg::FuncUnlock, 0, 0, 1'($urandom_range(0, 1)));
      end else if (sel < 98) begin
        send(prqs_pkg::FuncStart, 0, 0, 1'($urandom_range(0, 1)));
      end else begin
        send(3'($urandom_range(6, 7)), $urandom_range(0, 63), $urandom_range(0, 31),
             1'($urandom_range(0, 1)));
      end
    end
    drain();
    repeat (20) @(negedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
